@@ hdl/affine_matrix_inverse_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for affine_matrix_inverse_core
// Clocked, reset-qualified implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_INVERSE_CORE_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_CORE_MACROS_SVH

// same-cycle implication
`define AMI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ami_pkg.sv @@
// ----------------------------------------------------------------------------
// ami_pkg
// Types, constants and the multiply-accumulate program of the matrix inverse.
// ----------------------------------------------------------------------------
package ami_pkg;

  localparam int ROWS     = 3;
  localparam int COLS     = 4;
  localparam int NUM_ELEM = ROWS * COLS;
  localparam int ELEM_W   = 32;
  localparam int POS_W    = 4;
  localparam int NUM_ADJ  = 9;
  localparam int ADJ_W    = 64;
  localparam int ACC_W    = 128;
  localparam int PROD_W   = 65;
  localparam int NUM_OPS  = 42;
  localparam int STEP_W   = 6;
  localparam int Q_W      = 33;
  localparam int REM_W    = ACC_W + 1;
  localparam int CNT_W    = 6;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_ELEM - 1);
  localparam logic [1:0]       LAST_ROW = 2'(ROWS - 1);
  localparam logic [1:0]       LAST_COL = 2'(COLS - 1);

  localparam logic [1:0] DST_NONE = 2'd0;
  localparam logic [1:0] DST_ADJ  = 2'd1;
  localparam logic [1:0] DST_DET  = 2'd2;
  localparam logic [1:0] DST_TR   = 2'd3;

  typedef struct packed {
    logic [3:0] a_idx;
    logic       b_adj;
    logic [3:0] b_idx;
    logic       hi;
    logic       sub;
    logic       clr;
    logic [1:0] dst;
    logic [3:0] dst_idx;
  } op_t;

  typedef struct packed {
    logic              load_en;
    logic              op_issue;
    logic              op_mul;
    logic              op_acc;
    op_t               op;
    logic              adj_rd;
    logic [3:0]        adj_raddr;
    logic              det_chk;
    logic              d_load;
    logic              d_sat;
    logic              d_iter;
    logic [CNT_W-1:0]  bit_idx;
    logic              d_out;
    logic              sing_out;
    logic [1:0]        row;
    logic [1:0]        col;
    logic [POS_W-1:0]  out_pos;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
  } status_t;

  function automatic op_t mk_op(input logic [3:0] a, input logic b_adj,
                                input logic [3:0] b, input logic hi,
                                input logic sub, input logic clr,
                                input logic [1:0] dst, input logic [3:0] didx);
    op_t o;
    o.a_idx   = a;
    o.b_adj   = b_adj;
    o.b_idx   = b;
    o.hi      = hi;
    o.sub     = sub;
    o.clr     = clr;
    o.dst     = dst;
    o.dst_idx = didx;
    return o;
  endfunction

  // adjugate minors, determinant, then negated translation sums
  function automatic op_t op_lookup(input logic [STEP_W-1:0] step);
    op_t o;
    o = mk_op(4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, DST_NONE, 4'd0);
    unique case (step)
      6'd0:  o = mk_op(4'd5, 1'b0, 4'd10, 1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd1:  o = mk_op(4'd6, 1'b0, 4'd9,  1'b0, 1'b1, 1'b0, DST_ADJ,  4'd0);
      6'd2:  o = mk_op(4'd2, 1'b0, 4'd9,  1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd3:  o = mk_op(4'd1, 1'b0, 4'd10, 1'b0, 1'b1, 1'b0, DST_ADJ,  4'd1);
      6'd4:  o = mk_op(4'd1, 1'b0, 4'd6,  1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd5:  o = mk_op(4'd2, 1'b0, 4'd5,  1'b0, 1'b1, 1'b0, DST_ADJ,  4'd2);
      6'd6:  o = mk_op(4'd6, 1'b0, 4'd8,  1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd7:  o = mk_op(4'd4, 1'b0, 4'd10, 1'b0, 1'b1, 1'b0, DST_ADJ,  4'd3);
      6'd8:  o = mk_op(4'd0, 1'b0, 4'd10, 1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd9:  o = mk_op(4'd2, 1'b0, 4'd8,  1'b0, 1'b1, 1'b0, DST_ADJ,  4'd4);
      6'd10: o = mk_op(4'd2, 1'b0, 4'd4,  1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd11: o = mk_op(4'd0, 1'b0, 4'd6,  1'b0, 1'b1, 1'b0, DST_ADJ,  4'd5);
      6'd12: o = mk_op(4'd4, 1'b0, 4'd9,  1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd13: o = mk_op(4'd5, 1'b0, 4'd8,  1'b0, 1'b1, 1'b0, DST_ADJ,  4'd6);
      6'd14: o = mk_op(4'd1, 1'b0, 4'd8,  1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd15: o = mk_op(4'd0, 1'b0, 4'd9,  1'b0, 1'b1, 1'b0, DST_ADJ,  4'd7);
      6'd16: o = mk_op(4'd0, 1'b0, 4'd5,  1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd17: o = mk_op(4'd1, 1'b0, 4'd4,  1'b0, 1'b1, 1'b0, DST_ADJ,  4'd8);
      6'd18: o = mk_op(4'd0, 1'b1, 4'd0,  1'b0, 1'b0, 1'b1, DST_NONE, 4'd0);
      6'd19: o = mk_op(4'd0, 1'b1, 4'd0,  1'b1, 1'b0, 1'b0, DST_NONE, 4'd0);
      6'd20: o = mk_op(4'd1, 1'b1, 4'd3,  1'b0, 1'b0, 1'b0, DST_NONE, 4'd0);
      6'd21: o = mk_op(4'd1, 1'b1, 4'd3,  1'b1, 1'b0, 1'b0, DST_NONE, 4'd0);
      6'd22: o = mk_op(4'd2, 1'b1, 4'd6,  1'b0, 1'b0, 1'b0, DST_NONE, 4'd0);
      6'd23: o = mk_op(4'd2, 1'b1, 4'd6,  1'b1, 1'b0, 1'b0, DST_DET,  4'd0);
      6'd24: o = mk_op(4'd3,  1'b1, 4'd0, 1'b0, 1'b1, 1'b1, DST_NONE, 4'd0);
      6'd25: o = mk_op(4'd3,  1'b1, 4'd0, 1'b1, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd26: o = mk_op(4'd7,  1'b1, 4'd1, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd27: o = mk_op(4'd7,  1'b1, 4'd1, 1'b1, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd28: o = mk_op(4'd11, 1'b1, 4'd2, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd29: o = mk_op(4'd11, 1'b1, 4'd2, 1'b1, 1'b1, 1'b0, DST_TR,   4'd0);
      6'd30: o = mk_op(4'd3,  1'b1, 4'd3, 1'b0, 1'b1, 1'b1, DST_NONE, 4'd0);
      6'd31: o = mk_op(4'd3,  1'b1, 4'd3, 1'b1, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd32: o = mk_op(4'd7,  1'b1, 4'd4, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd33: o = mk_op(4'd7,  1'b1, 4'd4, 1'b1, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd34: o = mk_op(4'd11, 1'b1, 4'd5, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd35: o = mk_op(4'd11, 1'b1, 4'd5, 1'b1, 1'b1, 1'b0, DST_TR,   4'd1);
      6'd36: o = mk_op(4'd3,  1'b1, 4'd6, 1'b0, 1'b1, 1'b1, DST_NONE, 4'd0);
      6'd37: o = mk_op(4'd3,  1'b1, 4'd6, 1'b1, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd38: o = mk_op(4'd7,  1'b1, 4'd7, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd39: o = mk_op(4'd7,  1'b1, 4'd7, 1'b1, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd40: o = mk_op(4'd11, 1'b1, 4'd8, 1'b0, 1'b1, 1'b0, DST_NONE, 4'd0);
      6'd41: o = mk_op(4'd11, 1'b1, 4'd8, 1'b1, 1'b1, 1'b0, DST_TR,   4'd2);
      default: o = mk_op(4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, DST_NONE, 4'd0);
    endcase
    return o;
  endfunction

endpackage

@@ hdl/ami_ctrl.sv @@
// ----------------------------------------------------------------------------
// ami_ctrl
// Sequencer: element loads, multiply-accumulate program, per-element divide.
// ----------------------------------------------------------------------------
module ami_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ami_pkg::POS_W-1:0]   in_position,
  input  ami_pkg::status_t            status,
  output logic                        busy,
  output ami_pkg::cmd_t               cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ISSUE = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_DET   = 4'd4;
  localparam logic [3:0] S_DADDR = 4'd5;
  localparam logic [3:0] S_DLOAD = 4'd6;
  localparam logic [3:0] S_DSAT  = 4'd7;
  localparam logic [3:0] S_DITER = 4'd8;
  localparam logic [3:0] S_DOUT  = 4'd9;

  logic [3:0]                     state_r, state_nxt;
  logic [ami_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [1:0]                     row_r, row_nxt;
  logic [1:0]                     col_r, col_nxt;
  logic [ami_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           last_elem;

  assign busy      = (state_r != S_IDLE);
  assign last_elem = (row_r == ami_pkg::LAST_ROW) && (col_r == ami_pkg::LAST_COL);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cnt_nxt   = cnt_r;
    cmd           = '0;
    cmd.op        = ami_pkg::op_lookup(step_r);
    cmd.row       = row_r;
    cmd.col       = col_r;
    cmd.bit_idx   = cnt_r;
    cmd.out_pos   = {row_r, col_r};
    cmd.out_last  = last_elem;
    cmd.adj_raddr = cmd.op.b_idx;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_en = start && (in_position <= ami_pkg::LAST_POS);
        if (start && (in_position == ami_pkg::LAST_POS)) begin
          state_nxt = S_ISSUE;
          step_nxt  = '0;
        end
      end
      S_ISSUE: begin
        cmd.op_issue = 1'b1;
        cmd.adj_rd   = cmd.op.b_adj;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.op_mul = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.op_acc = 1'b1;
        if (step_r == ami_pkg::STEP_W'(ami_pkg::NUM_OPS - 1)) begin
          state_nxt = S_DET;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_DET: begin
        cmd.det_chk = 1'b1;
        row_nxt     = '0;
        col_nxt     = '0;
        if (status.det_zero) begin
          cmd.sing_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_DADDR;
        end
      end
      S_DADDR: begin
        cmd.adj_rd    = (col_r != ami_pkg::LAST_COL);
        cmd.adj_raddr = 4'(row_r) * 4'd3 + 4'(col_r);
        state_nxt     = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.d_load = 1'b1;
        state_nxt  = S_DSAT;
      end
      S_DSAT: begin
        cmd.d_sat = 1'b1;
        cnt_nxt   = ami_pkg::CNT_W'(ami_pkg::Q_W - 1);
        state_nxt = S_DITER;
      end
      S_DITER: begin
        cmd.d_iter = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DOUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DOUT: begin
        cmd.d_out = 1'b1;
        if (last_elem) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DADDR;
          if (col_r == ami_pkg::LAST_COL) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hdl/ami_datapath.sv @@
// ----------------------------------------------------------------------------
// ami_datapath
// Element store, shared multiplier and accumulator, radix-2 rounding divider.
// ----------------------------------------------------------------------------
module ami_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ami_pkg::cmd_t                    cmd,
  input  logic [ami_pkg::POS_W-1:0]        in_position,
  input  logic signed [ami_pkg::ELEM_W-1:0] in_value,
  output ami_pkg::status_t                 status,
  output logic                             out_strobe,
  output logic signed [ami_pkg::ELEM_W-1:0] out_value,
  output logic [ami_pkg::POS_W-1:0]        out_position,
  output logic                             out_singular,
  output logic                             out_last
);

  localparam int AW = ami_pkg::ACC_W;

  logic [ami_pkg::ELEM_W-1:0] elem_mem [ami_pkg::NUM_ELEM];
  logic [ami_pkg::ADJ_W-1:0]  adj_mem  [ami_pkg::NUM_ADJ];
  logic [AW-1:0]              tr_r     [ami_pkg::ROWS];

  logic [ami_pkg::ELEM_W-1:0] ea_r, eb_r;
  logic [ami_pkg::ADJ_W-1:0]  adj_rd_r;
  logic signed [ami_pkg::PROD_W-1:0] prod_r;
  logic [AW-1:0]              acc_r, acc_nxt, addend, base, prod_ext;
  logic [AW-1:0]              det_r, absd_r, d2;
  logic                       det_neg_r;
  logic signed [ami_pkg::ELEM_W:0] b_op;

  logic [AW-1:0]              num, absn, n_r;
  logic                       neg_r, sat_r;
  logic [ami_pkg::REM_W-1:0]  rem_r, rem2;
  logic [ami_pkg::Q_W-1:0]    q_r, n_low;
  logic                       ge;
  logic [ami_pkg::ELEM_W-1:0] res;

  logic                       out_strobe_r;
  logic [ami_pkg::ELEM_W-1:0] out_value_r;
  logic [ami_pkg::POS_W-1:0]  out_position_r;
  logic                       out_singular_r, out_last_r;

  assign status.det_zero = (det_r == '0);

  always_comb begin
    unique case ({cmd.op.b_adj, cmd.op.hi})
      2'b11:   b_op = {adj_rd_r[ami_pkg::ADJ_W-1], adj_rd_r[ami_pkg::ADJ_W-1:32]};
      2'b10:   b_op = {1'b0, adj_rd_r[31:0]};
      default: b_op = {eb_r[ami_pkg::ELEM_W-1], eb_r};
    endcase
  end

  assign prod_ext = {{(AW-ami_pkg::PROD_W){prod_r[ami_pkg::PROD_W-1]}}, prod_r};
  assign addend   = cmd.op.hi ? {prod_ext[AW-33:0], 32'b0} : prod_ext;
  assign base     = cmd.op.clr ? '0 : acc_r;
  assign acc_nxt  = cmd.op.sub ? (base - addend) : (base + addend);

  assign d2 = {absd_r[AW-2:0], 1'b0};
  assign num = (cmd.col == ami_pkg::LAST_COL) ?
               {tr_r[cmd.row][AW-17:0], 16'b0} :
               {{32{adj_rd_r[ami_pkg::ADJ_W-1]}}, adj_rd_r, 32'b0};
  assign absn  = num[AW-1] ? (~num + 1'b1) : num;
  assign n_low = n_r[ami_pkg::Q_W-1:0];
  assign rem2  = {rem_r[ami_pkg::REM_W-2:0], n_low[cmd.bit_idx]};
  assign ge    = (rem2 >= {1'b0, d2});

  always_comb begin
    if (!neg_r) begin
      res = (sat_r || (q_r > 33'h07FFF_FFFF)) ? 32'h7FFF_FFFF : q_r[31:0];
    end else begin
      res = (sat_r || (q_r > 33'h08000_0000)) ? 32'h8000_0000 : (~q_r[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) elem_mem[in_position] <= in_value;
    if (cmd.op_issue) begin
      ea_r <= elem_mem[cmd.op.a_idx];
      eb_r <= elem_mem[cmd.op.b_idx];
    end
    if (cmd.adj_rd) adj_rd_r <= adj_mem[cmd.adj_raddr];
    if (cmd.op_mul) prod_r <= $signed(ea_r) * b_op;
    if (cmd.op_acc) begin
      acc_r <= acc_nxt;
      unique case (cmd.op.dst)
        ami_pkg::DST_ADJ: adj_mem[cmd.op.dst_idx] <= acc_nxt[ami_pkg::ADJ_W-1:0];
        ami_pkg::DST_DET: det_r <= acc_nxt;
        ami_pkg::DST_TR:  tr_r[cmd.op.dst_idx[1:0]] <= acc_nxt;
        default: ;
      endcase
    end
    if (cmd.det_chk) begin
      det_neg_r <= det_r[AW-1];
      absd_r    <= det_r[AW-1] ? (~det_r + 1'b1) : det_r;
    end
    if (cmd.d_load) begin
      neg_r <= num[AW-1] ^ det_neg_r;
      n_r   <= {absn[AW-2:0], 1'b0} + absd_r;
    end
    if (cmd.d_sat) begin
      sat_r <= ({{ami_pkg::Q_W{1'b0}}, n_r} >= {d2, {ami_pkg::Q_W{1'b0}}});
      rem_r <= ami_pkg::REM_W'(n_r >> ami_pkg::Q_W);
      q_r   <= '0;
    end
    if (cmd.d_iter) begin
      rem_r <= ge ? (rem2 - {1'b0, d2}) : rem2;
      q_r   <= {q_r[ami_pkg::Q_W-2:0], ge};
    end
    if (cmd.d_out) begin
      out_value_r    <= res;
      out_position_r <= cmd.out_pos;
      out_singular_r <= 1'b0;
      out_last_r     <= cmd.out_last;
    end else if (cmd.sing_out) begin
      out_value_r    <= '0;
      out_position_r <= '0;
      out_singular_r <= 1'b1;
      out_last_r     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.d_out || cmd.sing_out;
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_value    = out_value_r;
  assign out_position = out_position_r;
  assign out_singular = out_singular_r;
  assign out_last     = out_last_r;

endmodule

@@ hdl/affine_matrix_inverse_core.sv @@
// ----------------------------------------------------------------------------
// affine_matrix_inverse_core
// Q16.16 inverse of a 3x4 affine transform, loaded and emitted element-wise.
// ----------------------------------------------------------------------------
// Each load beat (start while busy is low) stores one element. A beat at position
// 11 stores the element and begins the inversion: 42 multiply-accumulate steps
// through the one shared 32x33 multiplier, each issued, multiplied and
// accumulated in turn, then the determinant test. A singular matrix gives a
// single result. Otherwise each of the 12 elements passes through the radix-2
// rounding divider (one quotient bit per cycle, 33 bits). Every result is
// on the out_ ports for exactly one cycle with out_strobe high and cannot be
// stalled; busy stays high until the final result is issued.
module affine_matrix_inverse_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ami_pkg::POS_W-1:0]         in_position,
  input  logic signed [ami_pkg::ELEM_W-1:0] in_value,
  output logic                              out_strobe,
  output logic signed [ami_pkg::ELEM_W-1:0] out_value,
  output logic [ami_pkg::POS_W-1:0]         out_position,
  output logic                              out_singular,
  output logic                              out_last
);

  ami_pkg::cmd_t    cmd;
  ami_pkg::status_t status;

  ami_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_position (in_position),
    .status      (status),
    .busy        (busy),
    .cmd         (cmd)
  );

  ami_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_position  (in_position),
    .in_value     (in_value),
    .status       (status),
    .out_strobe   (out_strobe),
    .out_value    (out_value),
    .out_position (out_position),
    .out_singular (out_singular),
    .out_last     (out_last)
  );

endmodule

@@ hdl/ami_checker.sv @@
// ----------------------------------------------------------------------------
// ami_checker
// Port-level checks of result framing and busy behavior.
// ----------------------------------------------------------------------------
`include "affine_matrix_inverse_core_macros.svh"

module ami_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [ami_pkg::POS_W-1:0]         in_position,
  input logic                              out_strobe,
  input logic signed [ami_pkg::ELEM_W-1:0] out_value,
  input logic [ami_pkg::POS_W-1:0]         out_position,
  input logic                              out_singular,
  input logic                              out_last
);

  `AMI_ASSERT_IMP(a_sing_form, out_strobe && out_singular, out_last && (out_value == '0) && (out_position == '0), "singular beat malformed")
  `AMI_ASSERT_IMP(a_last_pos, out_strobe && out_last && !out_singular, out_position == ami_pkg::LAST_POS, "last beat at wrong position")
  `AMI_ASSERT_NXT(a_strobe_pulse, out_strobe, !out_strobe, "back-to-back result beats")
  `AMI_ASSERT_NXT(a_start_busy, start && !busy && (in_position == ami_pkg::LAST_POS), busy, "final load did not start run")
  `AMI_ASSERT_IMP(a_mid_busy, out_strobe && !out_last, busy, "run ended before last beat")

endmodule

bind affine_matrix_inverse_core ami_checker u_ami_checker (.*);
